FILE: design/cma_pkg.sv
// Shared constants, types and a function for the calendar month adder.
`default_nettype none
package cma_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int DELTA_W = 18;
	localparam int STAT_W  = 2;

	localparam int YEAR_MAX      = 9999;
	localparam int MONTHS        = 12;
	localparam int DIV12_BIAS_Q  = 11000;
	localparam int DIV12_BIAS    = DIV12_BIAS_Q * MONTHS;
	localparam int DIV12_X_W     = 19;
	localparam int DIV12_Q_W     = 16;
	localparam int RECIP12       = 43691;
	localparam int RECIP12_SHIFT = 19;
	localparam int RECIP25       = 5243;
	localparam int RECIP25_SHIFT = 17;
	localparam int Q25_W         = 10;
	localparam int YSUM_W        = 20;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_RANGE     = 2'd1,
		ST_BAD_MONTH = 2'd2
	} cma_status_t;

	typedef struct packed {
		logic s2;
		logic s3;
	} cma_div_en_t;

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
		input logic leap);
		logic [DAY_W-1:0] len;
		begin
			unique case (month)
				4'd2: len = leap ? 5'd29 : 5'd28;
				4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
				default: len = 5'd31;
			endcase
			return len;
		end
	endfunction

endpackage
`default_nettype wire

FILE: design/cma_div12.sv
// Two-stage floor division by twelve of a biased month count.
`default_nettype none
module cma_div12
	import cma_pkg::*;
(
	input  wire logic                 clk,
	input  wire cma_div_en_t          en,
	input  wire logic [DIV12_X_W-1:0] x,
	output logic      [DIV12_Q_W-1:0] q,
	output logic      [MONTH_W-1:0]   r
);

	localparam int PROD_W = DIV12_X_W + DIV12_Q_W;
	localparam int DIFF_W = DIV12_X_W + 2;

	logic [PROD_W-1:0]    prod;
	logic [DIV12_Q_W-1:0] q0_s2;
	logic [DIV12_X_W-1:0] x_s2;
	logic [DIFF_W-1:0]    diff;
	logic                 neg;
	logic [DIV12_Q_W-1:0] q_s3;
	logic [MONTH_W-1:0]   r_s3;

	assign prod = PROD_W'(x) * PROD_W'(RECIP12);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			q0_s2 <= prod[PROD_W-1:RECIP12_SHIFT];
			x_s2  <= x;
		end
	end

	assign diff = DIFF_W'(x_s2) - DIFF_W'(q0_s2) * DIFF_W'(MONTHS);
	assign neg  = diff[DIFF_W-1];

	always_ff @(posedge clk) begin
		if (en.s3) begin
			q_s3 <= neg ? q0_s2 - DIV12_Q_W'(1) : q0_s2;
			r_s3 <= neg ? diff[MONTH_W-1:0] + MONTH_W'(MONTHS) : diff[MONTH_W-1:0];
		end
	end

	assign q = q_s3;
	assign r = r_s3;

endmodule
`default_nettype wire

FILE: design/calendar_month_adder_top.sv
// Top level of the calendar month adder pipeline.
// Shifts a date by a signed count of months or years and clamps the day to the
// new month's length. Six register stages: input capture, reciprocal multiply
// for the division by twelve, quotient correction, year add, reciprocal
// multiply for the century test, then clamp and saturation into the output
// register. One transaction is accepted per cycle unless the pipeline is full
// behind a stalled output; a stalled output backs up only as far as empty
// stages allow.
`default_nettype none
module calendar_month_adder_top
	import cma_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [13:0] start_year, [17:14] start_month, [22:18] start_day,
	// [40:23] delta_amount, [47:41] zero
	input  wire logic [47:0] s_axis_tdata,
	// [0] req_type
	input  wire logic        s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [13:0] result_year, [17:14] result_month, [22:18] result_day,
	// [24:23] status, [31:25] zero
	output logic      [31:0] m_axis_tdata
);

	logic [YEAR_W-1:0]  in_year;
	logic [MONTH_W-1:0] in_month;
	logic [DAY_W-1:0]   in_day;
	logic [DELTA_W-1:0] in_delta;
	logic [MONTH_W-1:0] in_mon0;
	logic [YSUM_W-1:0]  x_sum;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_v_q;
	logic en1, en2, en3, en4, en5, en6;
	cma_div_en_t div_en;

	logic               type_s1, type_s2, type_s3;
	logic [YEAR_W-1:0]  year_s1, year_s2, year_s3;
	logic [MONTH_W-1:0] mon0_s1, mon0_s2, mon0_s3;
	logic [DELTA_W-1:0] delta_s1, delta_s2, delta_s3;
	logic [DAY_W-1:0]   day_s1, day_s2, day_s3, day_s4, day_s5;
	logic               bad_s1, bad_s2, bad_s3, bad_s4, bad_s5;
	logic [DIV12_X_W-1:0] x_s1;

	logic [DIV12_Q_W-1:0] div_q;
	logic [MONTH_W-1:0]   div_r;

	logic [DELTA_W:0]   qs;
	logic [YSUM_W-1:0]  year_sum;
	logic [MONTH_W-1:0] month_new;
	logic [YSUM_W-1:0]  year_s4, year_s5;
	logic [MONTH_W-1:0] month_s4, month_s5;

	localparam int P25_W = YEAR_W + 13;
	logic [P25_W-1:0]  prod25;
	logic [Q25_W-1:0]  q25_s5;

	logic [YEAR_W-1:0]  y_lo;
	logic               div25, leap, yr_low, yr_high;
	logic [DAY_W-1:0]   len;

	logic [YEAR_W-1:0]  res_year_q;
	logic [MONTH_W-1:0] res_month_q;
	logic [DAY_W-1:0]   res_day_q;
	cma_status_t        status_q;

	assign in_year  = s_axis_tdata[13:0];
	assign in_month = s_axis_tdata[17:14];
	assign in_day   = s_axis_tdata[22:18];
	assign in_delta = s_axis_tdata[40:23];
	assign in_mon0  = in_month - MONTH_W'(1);
	assign x_sum    = {{(YSUM_W-DELTA_W){in_delta[DELTA_W-1]}}, in_delta}
		+ YSUM_W'(in_mon0) + YSUM_W'(DIV12_BIAS);

	assign en6 = !out_v_q || m_axis_tready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_axis_tready = en1;
	assign div_en = '{s2: en2, s3: en3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_axis_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) out_v_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			type_s1  <= s_axis_tuser;
			year_s1  <= in_year;
			mon0_s1  <= in_mon0;
			day_s1   <= in_day;
			delta_s1 <= in_delta;
			bad_s1   <= (in_month < MONTH_W'(1)) || (in_month > MONTH_W'(MONTHS));
			x_s1     <= x_sum[DIV12_X_W-1:0];
		end
		if (en2) begin
			type_s2  <= type_s1;
			year_s2  <= year_s1;
			mon0_s2  <= mon0_s1;
			day_s2   <= day_s1;
			delta_s2 <= delta_s1;
			bad_s2   <= bad_s1;
		end
		if (en3) begin
			type_s3  <= type_s2;
			year_s3  <= year_s2;
			mon0_s3  <= mon0_s2;
			day_s3   <= day_s2;
			delta_s3 <= delta_s2;
			bad_s3   <= bad_s2;
		end
		if (en4) begin
			year_s4  <= year_sum;
			month_s4 <= month_new;
			day_s4   <= day_s3;
			bad_s4   <= bad_s3;
		end
		if (en5) begin
			year_s5  <= year_s4;
			month_s5 <= month_s4;
			day_s5   <= day_s4;
			bad_s5   <= bad_s4;
			q25_s5   <= prod25[P25_W-1:RECIP25_SHIFT];
		end
	end

	cma_div12 u_div12 (
		.clk (clk),
		.en  (div_en),
		.x   (x_s1),
		.q   (div_q),
		.r   (div_r)
	);

	assign qs = type_s3 ? {delta_s3[DELTA_W-1], delta_s3}
		: (DELTA_W+1)'(div_q) - (DELTA_W+1)'(DIV12_BIAS_Q);
	assign year_sum  = {{(YSUM_W-DELTA_W-1){qs[DELTA_W]}}, qs} + YSUM_W'(year_s3);
	assign month_new = (type_s3 ? mon0_s3 : div_r) + MONTH_W'(1);

	assign prod25 = P25_W'(year_s4[YEAR_W-1:0]) * P25_W'(RECIP25);

	assign y_lo    = year_s5[YEAR_W-1:0];
	assign div25   = (YEAR_W'(q25_s5) * YEAR_W'(25)) == y_lo;
	assign leap    = (y_lo[1:0] == 2'd0) && (!div25 || (y_lo[3:0] == 4'd0));
	assign len     = month_days(month_s5, leap);
	assign yr_low  = year_s5[YSUM_W-1];
	assign yr_high = !yr_low && (year_s5 > YSUM_W'(YEAR_MAX));

	always_ff @(posedge clk) begin
		if (en6) begin
			priority if (bad_s5) begin
				res_year_q  <= '0;
				res_month_q <= '0;
				res_day_q   <= '0;
				status_q    <= ST_BAD_MONTH;
			end else if (yr_low) begin
				res_year_q  <= '0;
				res_month_q <= MONTH_W'(1);
				res_day_q   <= DAY_W'(1);
				status_q    <= ST_RANGE;
			end else if (yr_high) begin
				res_year_q  <= YEAR_W'(YEAR_MAX);
				res_month_q <= MONTH_W'(MONTHS);
				res_day_q   <= DAY_W'(31);
				status_q    <= ST_RANGE;
			end else begin
				res_year_q  <= y_lo;
				res_month_q <= month_s5;
				res_day_q   <= (day_s5 > len) ? len : day_s5;
				status_q    <= ST_OK;
			end
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {7'd0, status_q, res_day_q, res_month_q, res_year_q};

	a_stall_from_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (out_v_q && !m_axis_tready))
		else $error("input stalled while output is free");

	a_div_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !type_s3) |-> (div_r < MONTH_W'(MONTHS)))
		else $error("month remainder out of range");

	a_ok_month: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && status_q == ST_OK) |->
		(res_month_q >= MONTH_W'(1) && res_month_q <= MONTH_W'(MONTHS)
		&& res_year_q <= YEAR_W'(YEAR_MAX)))
		else $error("ok result with bad month or year");

	a_range_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && status_q == ST_RANGE) |->
		(res_year_q == '0 || res_year_q == YEAR_W'(YEAR_MAX)))
		else $error("saturated year not at a range end");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && status_q == ST_BAD_MONTH) |->
		(res_year_q == '0 && res_month_q == '0 && res_day_q == '0))
		else $error("invalid month result not cleared");

endmodule
`default_nettype wire
